>>> rtl/opa_pkg.sv
// opa_pkg: shared types and codes for the object pool allocator
// request and response payload structs, request and status codes
// no dependencies
`default_nettype none

package opa_pkg;

   // handles are 8 bits wide, so at most this many can ever be issued
   localparam int HANDLE_SPACE = 256;

   typedef enum logic [1:0] {
      REQ_ALLOC = 2'd0,
      REQ_TRY   = 2'd1,
      REQ_FREE  = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      STAT_OK            = 2'd0,
      STAT_POOL_FULL     = 2'd1,
      STAT_NONE_RELEASED = 2'd2,
      STAT_NOT_ALLOCATED = 2'd3
   } status_code_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] handle;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] handle_out;
      logic [1:0] status;
   } rsp_payload_type;

endpackage

`default_nettype wire

>>> rtl/opa_ram.sv
// opa_ram: simple dual-port RAM, one write port and one read port
// read data is registered; no contents reset
// no dependencies
`default_nettype none

module opa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/object_pool_allocator.sv
// object_pool_allocator: handle pool with a fifo free list and an allocated bitmap
// depends on opa_pkg and opa_ram
//
// Each request is handled in steps: a read of the free-list RAM at the head
// pointer and of the allocated-bitmap RAM at the request's handle, then an update
// that decides, writes both RAMs back and loads the response register, and that
// waits for the registered read data of those two RAMs. req_ready is high whenever no
// request is in flight, so a new request is taken while the previous response
// still waits in the output register; a request in its update cycle holds there
// until that register is free. Handles run from 0 to min(CAPACITY, 256) - 1. The
// bitmap needs no clearing pass after reset: an entry counts as allocated only if
// its handle is below the fresh-handle counter, and every such entry was written
// when that handle was first issued.
`default_nettype none

module object_pool_allocator #(
   parameter int CAPACITY = 256
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire opa_pkg::req_payload_type req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output opa_pkg::rsp_payload_type     rsp_data
);

   import opa_pkg::*;

   localparam int HandleLimit = (CAPACITY < HANDLE_SPACE) ? CAPACITY : HANDLE_SPACE;
   localparam int IdxW        = $clog2(HandleLimit);
   localparam int CntW        = $clog2(HandleLimit + 1);
   localparam logic [CntW-1:0] LimitCnt = CntW'(HandleLimit);
   localparam logic [IdxW-1:0] LastIdx  = IdxW'(HandleLimit - 1);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   function automatic logic [IdxW-1:0] ptr_next(input logic [IdxW-1:0] ptr);
      ptr_next = (ptr == LastIdx) ? '0 : ptr + 1'b1;
   endfunction

   state_type       state_ff, state_in;
   logic [1:0]      type_ff, type_in;
   logic [7:0]      handle_ff, handle_in;
   logic [IdxW-1:0] head_ff, head_in;
   logic [IdxW-1:0] tail_ff, tail_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] fresh_ff, fresh_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            accept;
   logic            commit;
   logic            in_use;
   logic            do_pop, do_fresh, do_push, do_clear;
   status_code_type status_code;
   logic [7:0]      hout;

   logic [7:0]      fifo_rdata;
   logic            map_rdata;
   logic            map_we;
   logic [IdxW-1:0] map_waddr;
   logic [IdxW-1:0] map_raddr;
   logic            fifo_we;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   // update only when the response register can take the result
   assign commit    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   // keep the bitmap read address steady while a request waits to commit
   assign map_raddr = accept ? req_data.handle[IdxW-1:0] : handle_ff[IdxW-1:0];

   // entries at or above the fresh counter were never issued
   assign in_use = ({1'b0, handle_ff} < 9'(fresh_ff)) && map_rdata;

   always_comb begin
      do_pop      = 1'b0;
      do_fresh    = 1'b0;
      do_push     = 1'b0;
      do_clear    = 1'b0;
      status_code = STAT_OK;
      case (type_ff)
         REQ_ALLOC: begin
            if (count_ff != '0) begin
               do_pop = 1'b1;
            end else if (fresh_ff < LimitCnt) begin
               do_fresh = 1'b1;
            end else begin
               status_code = STAT_POOL_FULL;
            end
         end
         REQ_TRY: begin
            if (count_ff != '0) begin
               do_pop = 1'b1;
            end else begin
               status_code = STAT_NONE_RELEASED;
            end
         end
         REQ_FREE: begin
            if (!in_use) begin
               status_code = STAT_NOT_ALLOCATED;
            end else begin
               do_clear = 1'b1;
               do_push  = (count_ff != LimitCnt);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (do_pop) begin
         hout = fifo_rdata;
      end else if (do_fresh) begin
         hout = 8'(fresh_ff);
      end else begin
         hout = '0;
      end
   end

   assign map_we  = commit && (do_pop || do_fresh || do_clear);
   assign fifo_we = commit && do_push;

   always_comb begin
      if (do_pop) begin
         map_waddr = fifo_rdata[IdxW-1:0];
      end else if (do_fresh) begin
         map_waddr = fresh_ff[IdxW-1:0];
      end else begin
         map_waddr = handle_ff[IdxW-1:0];
      end
   end

   opa_ram #(
      .WIDTH (8),
      .DEPTH (HandleLimit)
   ) u_free_list (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (tail_ff),
      .wr_data (handle_ff),
      .rd_addr (head_ff),
      .rd_data (fifo_rdata)
   );

   opa_ram #(
      .WIDTH (1),
      .DEPTH (HandleLimit)
   ) u_in_use_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (!do_clear),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      type_in      = type_ff;
      handle_in    = handle_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      fresh_in     = fresh_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         type_in   = req_data.req_type;
         handle_in = req_data.handle;
         state_in  = S_EXEC;
      end

      if (commit) begin
         if (do_pop) begin
            head_in  = ptr_next(head_ff);
            count_in = count_ff - 1'b1;
         end
         if (do_push) begin
            tail_in  = ptr_next(tail_ff);
            count_in = count_ff + 1'b1;
         end
         if (do_fresh) begin
            fresh_in = fresh_ff + 1'b1;
         end
         rsp_valid_in           = 1'b1;
         rsp_data_in.handle_out = hout;
         rsp_data_in.status     = status_code;
         state_in               = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff     <= type_in;
      handle_ff   <= handle_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LimitCnt)
      else $error("free list count above handle limit");

   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= LimitCnt)
      else $error("fresh counter above handle limit");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted request did not enter update cycle");

   a_full_only_exhausted: assert property (@(posedge clock) disable iff (reset)
      (commit && status_code == STAT_POOL_FULL) |->
         (count_ff == '0 && fresh_ff == LimitCnt))
      else $error("pool_full reported while handles remain");

   a_commit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("committed request did not produce a response");

endmodule

`default_nettype wire

>>> bench/object_pool_allocator_test.sv
// object_pool_allocator_test: self-checking bench for the object pool allocator
// directed corner cases, a full exhaust/release/drain sweep and random mixed traffic
// depends on opa_pkg and the object_pool_allocator rtl
`timescale 1ns / 100ps

module object_pool_allocator_test;
   import opa_pkg::*;

   localparam int POOL_CAPACITY = 256;
   localparam int HANDLE_LIMIT = (POOL_CAPACITY < HANDLE_SPACE) ? POOL_CAPACITY : HANDLE_SPACE;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam int IDLE_PCT = 17;
   localparam int CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_data;

   // own copy of the pool state
   logic [7:0] released[$];
   logic [8:0] fresh_next = '0;
   logic [HANDLE_SPACE-1:0] in_use = '0;

   req_payload_type requests_queued[$];
   rsp_payload_type grants_due[$];
   rsp_payload_type due_grant;

   logic no_stall = 1'b0;
   int error_count = 0;
   int requests_sent = 0;
   int cycle_count = 0;
   int status_seen[4] = '{0, 0, 0, 0};

   object_pool_allocator #(
      .CAPACITY(POOL_CAPACITY)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // updates the pool copy and returns the grant that the request earns
   function automatic rsp_payload_type next_grant(req_payload_type r);
      rsp_payload_type g;
      g.handle_out = '0;
      g.status = STAT_OK;
      case (r.req_type)
         REQ_ALLOC, REQ_TRY: begin
            if (released.size() != 0) begin
               g.handle_out = released.pop_front();
               in_use[g.handle_out] = 1'b1;
            end else if (r.req_type == REQ_TRY) begin
               g.status = STAT_NONE_RELEASED;
            end else if (fresh_next < HANDLE_LIMIT) begin
               g.handle_out = fresh_next[7:0];
               in_use[fresh_next[7:0]] = 1'b1;
               fresh_next = fresh_next + 9'd1;
            end else begin
               g.status = STAT_POOL_FULL;
            end
         end
         REQ_FREE: begin
            if (!in_use[r.handle]) begin
               g.status = STAT_NOT_ALLOCATED;
            end else begin
               in_use[r.handle] = 1'b0;
               if (released.size() < HANDLE_SPACE) released = {released, r.handle};
            end
         end
         default: ;
      endcase
      return g;
   endfunction

   // a handle currently out, or a random one when none is
   function automatic logic [7:0] pick_held();
      logic [7:0] held[$];
      for (int i = 0; i < HANDLE_SPACE; i++) begin
         if (in_use[i]) held = {held, i[7:0]};
      end
      if (held.size() == 0) return 8'($urandom_range(255));
      return held[$urandom_range(held.size() - 1)];
   endfunction

   task automatic queue_request(logic [1:0] kind, logic [7:0] h);
      req_payload_type r;
      // keep the lag short so handle picks follow the pool state
      while (requests_queued.size() >= 4) @(posedge clock);
      r.req_type = kind;
      r.handle = h;
      requests_queued = {requests_queued, r};
   endtask

   task automatic wait_drained();
      while (requests_queued.size() != 0 || req_valid || grants_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic queue_mixed(int count, int alloc_w);
      int roll;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         if (roll < 6) queue_request(REQ_UNKNOWN, 8'($urandom_range(255)));
         else if (roll < 14) queue_request(REQ_FREE, 8'($urandom_range(255)));
         else if (roll < 14 + alloc_w) queue_request(REQ_ALLOC, 8'($urandom_range(255)));
         else if (roll < 24 + alloc_w) queue_request(REQ_TRY, 8'($urandom_range(255)));
         else queue_request(REQ_FREE, pick_held());
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            grants_due = {grants_due, next_grant(req_data)};
            requests_sent++;
         end
         if (!req_valid || req_ready) begin
            if (requests_queued.size() != 0 && (no_stall || $urandom_range(99) >= IDLE_PCT)) begin
               req_valid <= 1'b1;
               req_data <= requests_queued.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (grants_due.size() == 0) begin
               $error("response with no request outstanding: handle_out %0d status %0d",
                      rsp_data.handle_out, rsp_data.status);
               error_count++;
            end else begin
               due_grant = grants_due.pop_front();
               status_seen[due_grant.status]++;
               if (rsp_data.handle_out !== due_grant.handle_out) begin
                  $error("handle_out mismatch: expected %0d, got %0d",
                         due_grant.handle_out, rsp_data.handle_out);
                  error_count++;
               end
               if (rsp_data.status !== due_grant.status) begin
                  $error("status mismatch: expected %0d, got %0d",
                         due_grant.status, rsp_data.status);
                  error_count++;
               end
            end
         end
         rsp_ready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      logic [7:0] order[HANDLE_SPACE];
      logic [7:0] swap;
      int j;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      queue_request(REQ_TRY, 8'h00);       // empty free list
      queue_request(REQ_FREE, 8'h00);      // never issued
      queue_request(REQ_FREE, 8'hff);
      queue_request(REQ_ALLOC, 8'hff);
      queue_request(REQ_ALLOC, 8'h00);
      queue_request(REQ_ALLOC, 8'h55);
      queue_request(REQ_FREE, 8'h01);
      queue_request(REQ_FREE, 8'h01);      // double release
      queue_request(REQ_FREE, 8'h00);
      queue_request(REQ_UNKNOWN, 8'hff);   // ignored
      queue_request(REQ_UNKNOWN, 8'h00);
      queue_request(REQ_TRY, 8'haa);       // oldest released first
      queue_request(REQ_ALLOC, 8'h00);
      queue_request(REQ_TRY, 8'hff);
      queue_request(REQ_ALLOC, 8'h00);     // fresh again
      queue_request(REQ_FREE, 8'h03);
      queue_request(REQ_FREE, 8'h02);
      queue_request(REQ_FREE, 8'h80);      // above anything issued
      queue_request(REQ_ALLOC, 8'h00);
      queue_request(REQ_TRY, 8'h00);

      // sender holds off until every response is back
      wait_drained();

      queue_mixed(150, 45);
      queue_mixed(150, 25);

      // exhaust every handle, then hit pool_full
      wait_drained();
      for (int i = 0; i < HANDLE_SPACE + 4; i++) queue_request(REQ_ALLOC, 8'($urandom_range(255)));
      wait_drained();

      // release all handles in random order, no idling on either side
      for (int i = 0; i < HANDLE_SPACE; i++) order[i] = i[7:0];
      for (int i = HANDLE_SPACE - 1; i > 0; i--) begin
         j = $urandom_range(i);
         swap = order[i];
         order[i] = order[j];
         order[j] = swap;
      end
      no_stall <= 1'b1;
      for (int i = 0; i < HANDLE_SPACE; i++) begin
         if ($urandom_range(99) < 5) queue_request(REQ_UNKNOWN, 8'($urandom_range(255)));
         queue_request(REQ_FREE, order[i]);
      end
      queue_request(REQ_FREE, 8'($urandom_range(255)));
      queue_request(REQ_ALLOC, 8'($urandom_range(255)));
      wait_drained();
      no_stall <= 1'b0;

      // drain the free list through try allocate
      for (int i = 0; i < HANDLE_SPACE + 2; i++) queue_request(REQ_TRY, 8'($urandom_range(255)));

      for (int k = 0; k < 6; k++) queue_mixed($urandom_range(40, 100), 25 + 20 * (k % 3));

      wait_drained();
      repeat (10) @(posedge clock);
      $display("%0d requests: %0d ok, %0d pool full, %0d none released, %0d not allocated",
               requests_sent, status_seen[STAT_OK], status_seen[STAT_POOL_FULL],
               status_seen[STAT_NONE_RELEASED], status_seen[STAT_NOT_ALLOCATED]);
      $display("free list filled to all %0d handles and drained; %0d mismatches",
               HANDLE_SPACE, error_count);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
